// File: sv/frc_pkg.sv
// Package: shared types and constants for the FIFO-replacement cache directory.
`timescale 1ns / 1ps
`default_nettype none

package frc_pkg;

    localparam int SET_IDX_W = 6;
    localparam int TAG_W     = 32;
    localparam int STAMP_W   = 32;
    localparam int WAY_OUT_W = 2;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic [SET_IDX_W-1:0] set_index;
        logic [TAG_W-1:0]     tag;
        logic                 operation;
    } t_req;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic                 evicted_valid;
        logic [TAG_W-1:0]     evicted_tag;
        logic                 stamp_saturated;
    } t_rsp;

    // Sequencer to way compare unit
    typedef struct packed {
        logic en;
        logic first;
    } t_scan_ctl;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

endpackage

`default_nettype wire

// File: sv/frc_row_ram.sv
// Set row memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module frc_row_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 292,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: sv/frc_scan.sv
// Way compare unit: one tag match and one stamp compare per cycle while i_ctl.en is high, with running results.
`timescale 1ns / 1ps
`default_nettype none

module frc_scan
    import frc_pkg::*;
#(
    parameter int WAY_W = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_scan_ctl          i_ctl,
    input  wire logic [WAY_W-1:0]   i_way,
    input  wire logic               i_valid,
    input  wire logic [TAG_W-1:0]   i_tag,
    input  wire logic [STAMP_W-1:0] i_stamp,
    input  wire logic [TAG_W-1:0]   i_lookup,
    output logic                    o_found,
    output logic      [WAY_W-1:0]   o_hit_way,
    output logic      [WAY_W-1:0]   o_victim
);

    logic               r_found, n_found;
    logic [WAY_W-1:0]   r_hit_way, n_hit_way;
    logic [WAY_W-1:0]   r_victim, n_victim;
    logic [STAMP_W-1:0] r_low, n_low;
    logic               eq;
    logic [STAMP_W-1:0] eff_stamp;

    // invalid ways count as stamp zero
    assign eq        = i_valid && (i_tag == i_lookup);
    assign eff_stamp = i_valid ? i_stamp : '0;

    always_comb begin
        n_found   = r_found;
        n_hit_way = r_hit_way;
        n_victim  = r_victim;
        n_low     = r_low;
        if (i_ctl.en) begin
            if (i_ctl.first) begin
                n_found   = eq;
                n_hit_way = i_way;
                n_low     = eff_stamp;
                n_victim  = i_way;
            end else begin
                if (eq && !r_found) begin
                    n_found   = 1'b1;
                    n_hit_way = i_way;
                end
                // strict less: lowest index wins ties
                if (eff_stamp < r_low) begin
                    n_low    = eff_stamp;
                    n_victim = i_way;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_way <= n_hit_way;
        r_victim  <= n_victim;
        r_low     <= n_low;
    end

    assign o_found   = r_found;
    assign o_hit_way = r_hit_way;
    assign o_victim  = r_victim;

endmodule

`default_nettype wire

// File: sv/fifo_replacement_cache_set.sv
// Flow: an accepted start reads the set row, ST_SCAN steps the way compare unit through
// the ways, one way a cycle, and ST_UPDATE writes the row back; busy is high in both.
// The result beat is shown for one cycle and cannot be stalled by the receiver.
// Reset: synchronous, active low; afterwards a clearing pass zeroes every set row
// (valid bits and stamp counter) with busy held high.
// Top level: FIFO-replacement tag directory for a set-associative cache.
`timescale 1ns / 1ps
`default_nettype none

module fifo_replacement_cache_set
    import frc_pkg::*;
#(
    parameter int WAYS = 4,
    parameter int SETS = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_valid,
    output t_rsp      o_rsp
);

    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int IN_SETS = 1 << SET_IDX_W;

    // Row layout: valid bits | tags | stamps | set counter
    localparam int TAG_LSB   = WAYS;
    localparam int STAMP_LSB = TAG_LSB + WAYS * TAG_W;
    localparam int CNT_LSB   = STAMP_LSB + WAYS * STAMP_W;
    localparam int ROW_W     = CNT_LSB + STAMP_W;

    // set_index modulo SETS, worked out at elaboration
    logic [SET_W-1:0] set_mod [IN_SETS];
    for (genvar gi = 0; gi < IN_SETS; gi++) begin : g_set_mod
        assign set_mod[gi] = SET_W'(gi % SETS);
    end

    t_state           r_state, n_state;
    logic [SET_W-1:0] r_clr_addr, n_clr_addr;
    logic [WAY_W-1:0] r_step, n_step;
    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;
    logic             r_op;
    logic             r_valid, n_valid;
    t_rsp             r_rsp, n_rsp;

    logic             accept;
    logic             rd_en;
    logic             wr_en;
    logic [SET_W-1:0] wr_addr;
    logic [ROW_W-1:0] wr_row;
    logic [ROW_W-1:0] row;
    logic             last_step;
    t_scan_ctl        scan_ctl;

    logic             found;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] victim;

    logic [WAY_W-1:0]   sel;
    logic [STAMP_W-1:0] cnt, cnt_adv, new_cnt;
    logic               bump;
    logic [ROW_W-1:0]   upd_row;

    assign accept    = start && !busy;
    assign last_step = (r_step == WAY_W'(WAYS - 1));

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == SET_W'(SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_step) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        busy           = 1'b1;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        scan_ctl.en    = 1'b0;
        scan_ctl.first = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                wr_en = 1'b1;
            end
            ST_IDLE: begin
                busy  = 1'b0;
                rd_en = start;
            end
            ST_SCAN: begin
                scan_ctl.en    = 1'b1;
                scan_ctl.first = (r_step == '0);
            end
            ST_UPDATE: begin
                wr_en = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_clr_addr = r_clr_addr;
        n_step     = r_step;
        if (r_state == ST_CLEAR) begin
            n_clr_addr = r_clr_addr + SET_W'(1);
        end
        if (accept) begin
            n_step = '0;
        end else if (r_state == ST_SCAN && !last_step) begin
            n_step = r_step + WAY_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_step     <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_step     <= n_step;
            r_valid    <= n_valid;
        end
    end

    // request beat is held for the whole access
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set <= set_mod[i_req.set_index];
            r_tag <= i_req.tag;
            r_op  <= i_req.operation;
        end
        r_rsp <= n_rsp;
    end

    // ---------------------------------------------------------------- row memory
    assign wr_addr = (r_state == ST_CLEAR) ? r_clr_addr : r_set;
    assign wr_row  = (r_state == ST_CLEAR) ? '0 : upd_row;

    frc_row_ram #(
        .DEPTH (SETS),
        .WIDTH (ROW_W),
        .AW    (SET_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_row),
        .i_rd_en   (rd_en),
        .i_rd_addr (set_mod[i_req.set_index]),
        .o_rd_data (row)
    );

    // ---------------------------------------------------------------- way compare
    frc_scan #(
        .WAY_W (WAY_W)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (scan_ctl),
        .i_way     (r_step),
        .i_valid   (row[r_step]),
        .i_tag     (row[TAG_LSB + r_step * TAG_W +: TAG_W]),
        .i_stamp   (row[STAMP_LSB + r_step * STAMP_W +: STAMP_W]),
        .i_lookup  (r_tag),
        .o_found   (found),
        .o_hit_way (hit_way),
        .o_victim  (victim)
    );

    // ---------------------------------------------------------------- update
    // A miss fill and a write hit take a fresh stamp; a read hit leaves the row as is.
    assign sel     = found ? hit_way : victim;
    assign cnt     = row[CNT_LSB +: STAMP_W];
    assign cnt_adv = (cnt == STAMP_MAX) ? cnt : cnt + STAMP_W'(1);
    assign bump    = !found || (r_op == OP_WRITE);
    assign new_cnt = bump ? cnt_adv : cnt;

    always_comb begin
        upd_row = row;
        for (int w = 0; w < WAYS; w++) begin
            if (bump && (WAY_W'(w) == sel)) begin
                upd_row[STAMP_LSB + w * STAMP_W +: STAMP_W] = cnt_adv;
                if (!found) begin
                    upd_row[w]                           = 1'b1;
                    upd_row[TAG_LSB + w * TAG_W +: TAG_W] = r_tag;
                end
            end
        end
        upd_row[CNT_LSB +: STAMP_W] = new_cnt;
    end

    always_comb begin
        n_valid                 = (r_state == ST_UPDATE);
        n_rsp                   = r_rsp;
        if (r_state == ST_UPDATE) begin
            n_rsp.hit             = found;
            n_rsp.way             = WAY_OUT_W'(sel);
            n_rsp.evicted_valid   = !found && row[sel];
            n_rsp.evicted_tag     = (!found && row[sel])
                                    ? row[TAG_LSB + sel * TAG_W +: TAG_W] : '0;
            n_rsp.stamp_saturated = (new_cnt == STAMP_MAX);
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

`ifndef SYNTHESIS
    a_beat_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_UPDATE))
        else $error("result beat without an update cycle");

    a_busy_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> busy)
        else $error("accepting during clearing pass");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_rsp.hit && o_rsp.evicted_valid))
        else $error("hit reported with an eviction");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en))
        else $error("row memory read and written in one cycle");
`endif

endmodule

`default_nettype wire
